### design/rbnp_pkg.sv
package rbnp_pkg;

  localparam int COORD_BITS = 32;
  localparam int ID_BITS    = 16;
  localparam int FRAC_BITS  = 16;
  localparam int AXES       = 3;
  localparam int AXIS_BITS  = $clog2(AXES);
  localparam int REG_COUNT  = 6;
  localparam int INDEX_BITS = $clog2(REG_COUNT);

  // slab arithmetic widths
  localparam int DIFF_BITS  = COORD_BITS + 2;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int PPROD_BITS = 2 * COORD_BITS;
  localparam int PROD_BITS  = PPROD_BITS + 1;
  localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;

  // reciprocal divider
  localparam int QUOT_BITS    = 2 * FRAC_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(QUOT_BITS + 1);
  localparam int SAT_BITS     = (QUOT_BITS > COORD_BITS) ? QUOT_BITS : COORD_BITS;
  localparam logic [QUOT_BITS-1:0] DIVIDEND = {1'b1, {(2 * FRAC_BITS){1'b0}}};

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  localparam logic [INDEX_BITS-1:0] REG_ORIGIN_X = INDEX_BITS'(0);
  localparam logic [INDEX_BITS-1:0] REG_ORIGIN_Y = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] REG_ORIGIN_Z = INDEX_BITS'(2);
  localparam logic [INDEX_BITS-1:0] REG_DIR_X    = INDEX_BITS'(3);
  localparam logic [INDEX_BITS-1:0] REG_DIR_Y    = INDEX_BITS'(4);
  localparam logic [INDEX_BITS-1:0] REG_DIR_Z    = INDEX_BITS'(5);

  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
  localparam logic [COORD_BITS-1:0] FIX_ONE   = COORD_BITS'(1) << FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  we;
    logic [INDEX_BITS-1:0] index;
    logic [COORD_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [AXES-1:0]                 neg;
    logic [AXES-1:0][COORD_BITS-1:0] mag;
  } inv_t;

  typedef struct packed {
    logic [AXES-1:0][COORD_BITS-1:0] center;
    logic [AXES-1:0][COORD_BITS-1:0] size;
    logic                            active;
    logic [ID_BITS-1:0]              id;
    logic                            last;
  } box_t;

  typedef struct packed {
    logic                                active;
    logic                                last;
    logic [ID_BITS-1:0]                  id;
    logic [AXES-1:0][1:0][DIFF_BITS-1:0] diff;
  } entry_t;

endpackage

### design/rbnp_recip.sv
module rbnp_recip (
  input  logic              clk,
  input  logic              rst,
  input  rbnp_pkg::cfg_wr_t cfg,
  output rbnp_pkg::inv_t    inv,
  output logic              busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                                        state;
  logic [rbnp_pkg::AXES-1:0]                         dirty;
  logic [rbnp_pkg::AXES-1:0][rbnp_pkg::COORD_BITS-1:0] direction;
  logic [rbnp_pkg::AXIS_BITS-1:0]                    axis;
  logic [rbnp_pkg::DIV_CNT_BITS-1:0]                 count;
  logic [rbnp_pkg::COORD_BITS-1:0]                   divisor;
  logic                                              neg;
  logic [rbnp_pkg::COORD_BITS-1:0]                   rem;
  logic [rbnp_pkg::QUOT_BITS-1:0]                    quot;

  logic [rbnp_pkg::AXES-1:0]       dir_wr;
  logic [rbnp_pkg::AXES-1:0]       start_clr;
  logic [rbnp_pkg::AXIS_BITS-1:0]  pick;
  logic [rbnp_pkg::COORD_BITS-1:0] dsel;
  logic [rbnp_pkg::COORD_BITS-1:0] dmag;
  logic [rbnp_pkg::COORD_BITS:0]   trial;
  logic [rbnp_pkg::COORD_BITS:0]   trial_sub;
  logic                            ge;
  logic [rbnp_pkg::SAT_BITS-1:0]   qwide;
  logic [rbnp_pkg::SAT_BITS-1:0]   lim;

  assign dir_wr[0] = cfg.we && (cfg.index == rbnp_pkg::REG_DIR_X);
  assign dir_wr[1] = cfg.we && (cfg.index == rbnp_pkg::REG_DIR_Y);
  assign dir_wr[2] = cfg.we && (cfg.index == rbnp_pkg::REG_DIR_Z);

  always_comb begin
    pick = '0;
    for (int i = rbnp_pkg::AXES - 1; i >= 0; i--) begin
      if (dirty[i]) pick = rbnp_pkg::AXIS_BITS'(i);
    end
  end

  always_comb begin
    start_clr = '0;
    if (state == ST_IDLE) start_clr[pick] = 1'b1;
  end

  assign dsel      = direction[pick];
  assign dmag      = dsel[rbnp_pkg::COORD_BITS-1] ?
                     (~dsel + rbnp_pkg::COORD_BITS'(1)) : dsel;
  assign trial     = {rem, quot[rbnp_pkg::QUOT_BITS-1]};
  assign ge        = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign qwide     = rbnp_pkg::SAT_BITS'(quot);
  assign lim       = neg ? rbnp_pkg::SAT_BITS'(rbnp_pkg::COORD_MIN) :
                           rbnp_pkg::SAT_BITS'(rbnp_pkg::COORD_MAX);

  assign busy = (state != ST_IDLE) || (dirty != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      dirty        <= '0;
      direction[0] <= '0;
      direction[1] <= '0;
      direction[2] <= rbnp_pkg::FIX_ONE;
      inv.neg      <= '0;
      inv.mag[0]   <= rbnp_pkg::COORD_MAX;
      inv.mag[1]   <= rbnp_pkg::COORD_MAX;
      inv.mag[2]   <= rbnp_pkg::FIX_ONE;
    end else begin
      for (int i = 0; i < rbnp_pkg::AXES; i++) begin
        if (dir_wr[i]) direction[i] <= cfg.data;
      end
      // a write landing mid-division marks the axis again
      dirty <= (dirty & ~start_clr) | dir_wr;
      case (state)
        ST_IDLE: begin
          if (dirty != '0) state <= ST_RUN;
        end
        ST_RUN: begin
          if (count == rbnp_pkg::DIV_CNT_BITS'(rbnp_pkg::QUOT_BITS - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          inv.mag[axis] <= (qwide > lim) ? lim[rbnp_pkg::COORD_BITS-1:0] :
                                           qwide[rbnp_pkg::COORD_BITS-1:0];
          inv.neg[axis] <= neg;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      axis    <= pick;
      divisor <= dmag;
      neg     <= dsel[rbnp_pkg::COORD_BITS-1];
      rem     <= '0;
      quot    <= rbnp_pkg::DIVIDEND;
      count   <= '0;
    end else if (state == ST_RUN) begin
      rem   <= ge ? trial_sub[rbnp_pkg::COORD_BITS-1:0] : trial[rbnp_pkg::COORD_BITS-1:0];
      quot  <= {quot[rbnp_pkg::QUOT_BITS-2:0], ge};
      count <= count + rbnp_pkg::DIV_CNT_BITS'(1);
    end
  end

endmodule

### design/rbnp_front.sv
module rbnp_front (
  input  logic              clk,
  input  logic              rst,
  input  rbnp_pkg::cfg_wr_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  rbnp_pkg::box_t    box,
  input  logic              busy,
  input  logic              pop,
  output logic              q_valid,
  output rbnp_pkg::entry_t  q_entry
);

  logic [rbnp_pkg::AXES-1:0][rbnp_pkg::COORD_BITS-1:0] origin;
  logic [rbnp_pkg::AXES-1:0]                           origin_wr;

  rbnp_pkg::entry_t mem [rbnp_pkg::QUEUE_DEPTH];
  logic [rbnp_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [rbnp_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [rbnp_pkg::QCNT_BITS-1:0] count;

  logic                           accept;
  logic                           push;
  rbnp_pkg::entry_t               entry;
  logic [rbnp_pkg::DIFF_BITS-1:0] c_ext;
  logic [rbnp_pkg::DIFF_BITS-1:0] h_ext;
  logic [rbnp_pkg::DIFF_BITS-1:0] o_ext;

  assign origin_wr[0] = cfg.we && (cfg.index == rbnp_pkg::REG_ORIGIN_X);
  assign origin_wr[1] = cfg.we && (cfg.index == rbnp_pkg::REG_ORIGIN_Y);
  assign origin_wr[2] = cfg.we && (cfg.index == rbnp_pkg::REG_ORIGIN_Z);

  assign in_stall = busy || (count == rbnp_pkg::QCNT_BITS'(rbnp_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;
  // skipped boxes that do not close a pick carry no work
  assign push     = accept && (box.active || box.last);
  assign q_valid  = count != '0;
  assign q_entry  = mem[rd_ptr];

  // bounds relative to the origin, half size rounded towards minus infinity
  always_comb begin
    entry.active = box.active;
    entry.last   = box.last;
    entry.id     = box.id;
    c_ext        = '0;
    h_ext        = '0;
    o_ext        = '0;
    for (int i = 0; i < rbnp_pkg::AXES; i++) begin
      c_ext = {{2{box.center[i][rbnp_pkg::COORD_BITS-1]}}, box.center[i]};
      h_ext = {{3{box.size[i][rbnp_pkg::COORD_BITS-1]}},
               box.size[i][rbnp_pkg::COORD_BITS-1:1]};
      o_ext = {{2{origin[i][rbnp_pkg::COORD_BITS-1]}}, origin[i]};
      entry.diff[i][0] = c_ext - h_ext - o_ext;
      entry.diff[i][1] = c_ext + h_ext - o_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      for (int i = 0; i < rbnp_pkg::AXES; i++) begin
        if (origin_wr[i]) origin[i] <= cfg.data;
      end
      if (push) wr_ptr <= wr_ptr + rbnp_pkg::QPTR_BITS'(1);
      if (pop) rd_ptr <= rd_ptr + rbnp_pkg::QPTR_BITS'(1);
      case ({push, pop})
        2'b10:   count <= count + rbnp_pkg::QCNT_BITS'(1);
        2'b01:   count <= count - rbnp_pkg::QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry;
  end

endmodule

### design/rbnp_back.sv
module rbnp_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  rbnp_pkg::entry_t                 q_entry,
  output logic                             pop,
  input  rbnp_pkg::inv_t                   inv,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [rbnp_pkg::ID_BITS-1:0]     picked_id,
  output logic signed [rbnp_pkg::COORD_BITS-1:0] entry_distance
);

  typedef struct packed {
    logic                         valid;
    logic                         active;
    logic                         last;
    logic [rbnp_pkg::ID_BITS-1:0] id;
  } tag_t;

  logic en;
  tag_t tag1, tag2, tag3, tag4, tag5, tag6;

  logic [rbnp_pkg::DIFF_BITS-1:0]  d1   [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::DIFF_BITS-1:0]  abs1 [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::MAG_BITS-1:0]   m2   [rbnp_pkg::AXES][2];
  logic                            n2   [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::PPROD_BITS-1:0] p_c  [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::PPROD_BITS-1:0] p3   [rbnp_pkg::AXES][2];
  logic                            top3 [rbnp_pkg::AXES][2];
  logic                            n3   [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::PROD_BITS-1:0]  full_c [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::COORD_BITS-1:0] lim_c  [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::COORD_BITS-1:0] r_c  [rbnp_pkg::AXES][2];
  logic [rbnp_pkg::COORD_BITS-1:0] r4   [rbnp_pkg::AXES][2];
  logic                            n4   [rbnp_pkg::AXES][2];
  rbnp_pkg::coord_t                t_c  [rbnp_pkg::AXES][2];
  rbnp_pkg::coord_t                lo_c [rbnp_pkg::AXES];
  rbnp_pkg::coord_t                hi_c [rbnp_pkg::AXES];
  rbnp_pkg::coord_t                lo5  [rbnp_pkg::AXES];
  rbnp_pkg::coord_t                hi5  [rbnp_pkg::AXES];
  rbnp_pkg::coord_t                te_c;
  rbnp_pkg::coord_t                tx_c;
  rbnp_pkg::coord_t                te6;
  rbnp_pkg::coord_t                tx6;

  rbnp_pkg::coord_t             best;
  logic [rbnp_pkg::ID_BITS-1:0] best_id;
  logic                         found;
  logic                         take;
  logic                         new_found;
  rbnp_pkg::coord_t             new_best;
  logic [rbnp_pkg::ID_BITS-1:0] new_id;

  assign en  = !out_valid || !out_stall;
  assign pop = en && q_valid;

  always_comb begin
    for (int i = 0; i < rbnp_pkg::AXES; i++) begin
      for (int j = 0; j < 2; j++) begin
        abs1[i][j] = d1[i][j][rbnp_pkg::DIFF_BITS-1] ?
                     (~d1[i][j] + rbnp_pkg::DIFF_BITS'(1)) : d1[i][j];
        p_c[i][j]  = rbnp_pkg::PPROD_BITS'(m2[i][j][rbnp_pkg::COORD_BITS-1:0]) *
                     rbnp_pkg::PPROD_BITS'(inv.mag[i]);
        full_c[i][j] = rbnp_pkg::PROD_BITS'(p3[i][j]) +
                       (top3[i][j] ?
                        rbnp_pkg::PROD_BITS'({inv.mag[i], {rbnp_pkg::COORD_BITS{1'b0}}}) :
                        rbnp_pkg::PROD_BITS'(0));
        lim_c[i][j] = n3[i][j] ? rbnp_pkg::COORD_MIN : rbnp_pkg::COORD_MAX;
        r_c[i][j]   = (full_c[i][j][rbnp_pkg::PROD_BITS-1:rbnp_pkg::FRAC_BITS] >
                       rbnp_pkg::SHIFT_BITS'(lim_c[i][j])) ? lim_c[i][j] :
                      full_c[i][j][rbnp_pkg::FRAC_BITS+rbnp_pkg::COORD_BITS-1:
                                   rbnp_pkg::FRAC_BITS];
        t_c[i][j]   = n4[i][j] ?
                      rbnp_pkg::coord_t'(~r4[i][j] + rbnp_pkg::COORD_BITS'(1)) :
                      rbnp_pkg::coord_t'(r4[i][j]);
      end
      lo_c[i] = (t_c[i][0] < t_c[i][1]) ? t_c[i][0] : t_c[i][1];
      hi_c[i] = (t_c[i][0] < t_c[i][1]) ? t_c[i][1] : t_c[i][0];
    end
  end

  always_comb begin
    te_c = lo5[0];
    tx_c = hi5[0];
    for (int i = 1; i < rbnp_pkg::AXES; i++) begin
      if (lo5[i] > te_c) te_c = lo5[i];
      if (hi5[i] < tx_c) tx_c = hi5[i];
    end
  end

  // ties keep the earlier box
  assign take      = tag6.active && (te6 <= tx6) && (tx6 > 0) && (te6 < best);
  assign new_found = found || take;
  assign new_best  = take ? te6 : best;
  assign new_id    = take ? tag6.id : best_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1      <= '0;
      tag2      <= '0;
      tag3      <= '0;
      tag4      <= '0;
      tag5      <= '0;
      tag6      <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      best      <= rbnp_pkg::COORD_MAX;
      best_id   <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (en) begin
        tag1.valid  <= q_valid;
        tag1.active <= q_entry.active;
        tag1.last   <= q_entry.last;
        tag1.id     <= q_entry.id;
        tag2        <= tag1;
        tag3        <= tag2;
        tag4        <= tag3;
        tag5        <= tag4;
        tag6        <= tag5;
        if (tag6.valid) begin
          if (tag6.last) begin
            out_valid <= 1'b1;
            found     <= 1'b0;
            best      <= rbnp_pkg::COORD_MAX;
            best_id   <= '0;
          end else begin
            found   <= new_found;
            best    <= new_best;
            best_id <= new_id;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < rbnp_pkg::AXES; i++) begin
        for (int j = 0; j < 2; j++) begin
          d1[i][j]   <= q_entry.diff[i][j];
          m2[i][j]   <= abs1[i][j][rbnp_pkg::MAG_BITS-1:0];
          n2[i][j]   <= d1[i][j][rbnp_pkg::DIFF_BITS-1] ^ inv.neg[i];
          p3[i][j]   <= p_c[i][j];
          top3[i][j] <= m2[i][j][rbnp_pkg::COORD_BITS];
          n3[i][j]   <= n2[i][j];
          r4[i][j]   <= r_c[i][j];
          n4[i][j]   <= n3[i][j];
        end
        lo5[i] <= lo_c[i];
        hi5[i] <= hi_c[i];
      end
      te6 <= te_c;
      tx6 <= tx_c;
      if (tag6.valid && tag6.last) begin
        hit            <= new_found;
        picked_id      <= new_found ? new_id : '0;
        entry_distance <= new_found ? new_best : '0;
      end
    end
  end

endmodule

### design/ray_box_nearest_pick.sv
// Throughput: one request per cycle through the six-stage slab pipeline while
// neither a held result nor a reciprocal update stalls requests.
// A direction write stalls requests while the shared radix-2 divider forms the
// reciprocal of each axis written, one axis after another.
// Reset: synchronous; origin zero, direction (0, 0, 1.0), pick state cleared.
module ray_box_nearest_pick (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [rbnp_pkg::INDEX_BITS-1:0]        cfg_index,
  input  logic [rbnp_pkg::COORD_BITS-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rbnp_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [rbnp_pkg::COORD_BITS-1:0] center_y,
  input  logic signed [rbnp_pkg::COORD_BITS-1:0] center_z,
  input  logic signed [rbnp_pkg::COORD_BITS-1:0] size_x,
  input  logic signed [rbnp_pkg::COORD_BITS-1:0] size_y,
  input  logic signed [rbnp_pkg::COORD_BITS-1:0] size_z,
  input  logic                                   active,
  input  logic [rbnp_pkg::ID_BITS-1:0]           object_id,
  input  logic                                   last_box,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   hit,
  output logic [rbnp_pkg::ID_BITS-1:0]           picked_id,
  output logic signed [rbnp_pkg::COORD_BITS-1:0] entry_distance
);

  rbnp_pkg::cfg_wr_t cfg;
  rbnp_pkg::box_t    box;
  rbnp_pkg::inv_t    inv;
  rbnp_pkg::entry_t  q_entry;
  logic              busy;
  logic              q_valid;
  logic              pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign box.center[0] = center_x;
  assign box.center[1] = center_y;
  assign box.center[2] = center_z;
  assign box.size[0]   = size_x;
  assign box.size[1]   = size_y;
  assign box.size[2]   = size_z;
  assign box.active    = active;
  assign box.id        = object_id;
  assign box.last      = last_box;

  rbnp_recip u_recip (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .inv  (inv),
    .busy (busy)
  );

  rbnp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .box      (box),
    .busy     (busy),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_entry  (q_entry)
  );

  rbnp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .inv            (inv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .picked_id      (picked_id),
    .entry_distance (entry_distance)
  );

endmodule

### design/rbnp_checker.sv
module rbnp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [rbnp_pkg::INDEX_BITS-1:0] cfg_index,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            hit,
  input logic [rbnp_pkg::ID_BITS-1:0]    picked_id,
  input logic [rbnp_pkg::COORD_BITS-1:0] entry_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(picked_id) &&
                               $stable(entry_distance))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (picked_id == '0) && (entry_distance == '0))
    else $error("miss result not zero");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> entry_distance != rbnp_pkg::COORD_MAX)
    else $error("hit with entry distance at the no-hit bound");

  a_dir_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == rbnp_pkg::REG_DIR_X || cfg_index == rbnp_pkg::REG_DIR_Y ||
               cfg_index == rbnp_pkg::REG_DIR_Z) |=> in_stall)
    else $error("request taken before reciprocal update");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_box_nearest_pick rbnp_checker u_rbnp_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .hit            (hit),
  .picked_id      (picked_id),
  .entry_distance (entry_distance)
);
